@@ src/qte_pkg.sv @@
package qte_pkg;

    // Input and output field widths.
    localparam int QW        = 16;
    localparam int ANGLE_W   = 16;

    // Square root datapath: the radicand is a Q30 value below 2^34 shifted left by 20.
    localparam int RAD_W     = 54;
    localparam int ROOT_W    = RAD_W / 2;
    localparam int REM_W     = ROOT_W + 3;
    localparam int ARG_W     = 36;

    // CORDIC datapath.
    localparam int X_W       = 37;
    localparam int Z_W       = 36;
    localparam int ATAN_LEN  = 24;
    localparam int CORDIC_STAGES_DEF = 16;

    localparam logic signed [Z_W-1:0] HALF_PI_Q30      = 36'sd1686629713;
    localparam logic signed [Z_W-1:0] FILE_HALF_PI_Q30 = 36'sd1686628352;
    localparam logic signed [ARG_W-1:0] ONE_Q30        = 36'sd1073741824;
    localparam logic signed [ANGLE_W-1:0] ANGLE_MAX    = 16'sd25736;

    // atan(2^-i) in Q30, rounded to nearest.
    function automatic logic signed [Z_W-1:0] atan_q30(input int i);
        logic signed [Z_W-1:0] r;
        case (i)
            0:       r = 36'sd843314857;
            1:       r = 36'sd497837829;
            2:       r = 36'sd263043837;
            3:       r = 36'sd133525159;
            4:       r = 36'sd67021687;
            5:       r = 36'sd33543516;
            6:       r = 36'sd16775851;
            7:       r = 36'sd8388437;
            8:       r = 36'sd4194283;
            9:       r = 36'sd2097149;
            10:      r = 36'sd1048576;
            11:      r = 36'sd524288;
            12:      r = 36'sd262144;
            13:      r = 36'sd131072;
            14:      r = 36'sd65536;
            15:      r = 36'sd32768;
            16:      r = 36'sd16384;
            17:      r = 36'sd8192;
            18:      r = 36'sd4096;
            19:      r = 36'sd2048;
            20:      r = 36'sd1024;
            21:      r = 36'sd512;
            22:      r = 36'sd256;
            23:      r = 36'sd128;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

@@ src/qte_sqrt_cell.sv @@
// One digit of a restoring integer square root: two radicand bits in, one root bit out.
module qte_sqrt_cell
    import qte_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [RAD_W-1:0]  rad_in,
    input  logic [REM_W-1:0]  rem_in,
    input  logic [ROOT_W-1:0] root_in,
    output logic [RAD_W-1:0]  rad_out,
    output logic [REM_W-1:0]  rem_out,
    output logic [ROOT_W-1:0] root_out
);

    logic [RAD_W-1:0]  rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [RAD_W-1:0]  rad_next;
    logic [REM_W-1:0]  rem_next;
    logic [ROOT_W-1:0] root_next;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              fits;

    always_comb
    begin
        rem_sh    = {rem_in[REM_W-3:0], rad_in[RAD_W-1 -: 2]};
        trial     = {1'b0, root_in, 2'b01};
        fits      = (rem_sh >= trial);
        rem_next  = fits ? (rem_sh - trial) : rem_sh;
        root_next = {root_in[ROOT_W-2:0], fits};
        rad_next  = {rad_in[RAD_W-3:0], 2'b00};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg  <= rad_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign rad_out  = rad_reg;
    assign rem_out  = rem_reg;
    assign root_out = root_reg;

endmodule

@@ src/qte_cordic_cell.sv @@
// One vectoring CORDIC micro-rotation with a fixed shift.
module qte_cordic_cell
    import qte_pkg::*;
#(
    parameter int SHIFT = 0
)
(
    input  logic                  clk,
    input  logic                  en,
    input  logic signed [X_W-1:0] x_in,
    input  logic signed [X_W-1:0] y_in,
    input  logic signed [Z_W-1:0] z_in,
    output logic signed [X_W-1:0] x_out,
    output logic signed [X_W-1:0] y_out,
    output logic signed [Z_W-1:0] z_out
);

    localparam logic signed [Z_W-1:0] ATAN = atan_q30(SHIFT);

    logic signed [X_W-1:0] x_reg, y_reg, x_next, y_next;
    logic signed [Z_W-1:0] z_reg, z_next;
    logic signed [X_W-1:0] dx, dy;

    always_comb
    begin
        dx = y_in >>> SHIFT;
        dy = x_in >>> SHIFT;
        if (!y_in[X_W-1])
        begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + ATAN;
        end
        else
        begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - ATAN;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule

@@ src/quaternion_to_euler_angles.sv @@
// Channel   Direction  Bits (lowest first)                          Meaning
// s_axis    in         tdata: quat_w, quat_x, quat_y, quat_z        one quaternion request
// m_axis    out        tdata: roll, pitch, yaw; tuser: root_clamped one angle request
//
// A request enters every cycle unless the pipe holds; the pipe is made mostly of
// the 27 square-root digit cells followed by the CORDIC cells.
// All stages advance together; they hold only when the output register is full and
// m_tready is low, so s_tready falls exactly then.
// rst_n clears the valid bits only; the datapath registers need no reset.
module quaternion_to_euler_angles
    import qte_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // quat_w, quat_x, quat_y, quat_z
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // roll_angle, pitch_angle, yaw_angle
    output logic        m_tuser    // root_clamped
);

    localparam int LANES = 3;  // roll, pitch, yaw

    // The whole pipe moves when the output register can take a request.
    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // Stage 0: the nine products of the quaternion components, each exact in Q30.
    logic signed [QW-1:0] qw, qx, qy, qz;
    assign qw = s_tdata[15:0];
    assign qx = s_tdata[31:16];
    assign qy = s_tdata[47:32];
    assign qz = s_tdata[63:48];

    logic signed [2*QW-1:0] wx_reg, yz_reg, xx_reg, yy_reg, wz_reg;
    logic signed [2*QW-1:0] xy_reg, zz_reg, wy_reg, xz_reg;
    logic                   v0_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            wx_reg <= qw * qx;
            yz_reg <= qy * qz;
            xx_reg <= qx * qx;
            yy_reg <= qy * qy;
            wz_reg <= qw * qz;
            xy_reg <= qx * qy;
            zz_reg <= qz * qz;
            wy_reg <= qw * qy;
            xz_reg <= qx * qz;
        end
    end

    // Stage 1: the atan2 operands, and the two square-root arguments clamped at zero.
    logic signed [ARG_W-1:0] sr_c, cr_c, sy_c, cy_c, t_c, a_c, b_c;
    logic                    flag_c;

    always_comb
    begin
        sr_c   = (ARG_W'(wx_reg) + ARG_W'(yz_reg)) <<< 1;
        cr_c   = ONE_Q30 - ((ARG_W'(xx_reg) + ARG_W'(yy_reg)) <<< 1);
        sy_c   = (ARG_W'(wz_reg) + ARG_W'(xy_reg)) <<< 1;
        cy_c   = ONE_Q30 - ((ARG_W'(yy_reg) + ARG_W'(zz_reg)) <<< 1);
        t_c    = ARG_W'(wy_reg) - ARG_W'(xz_reg);
        a_c    = ONE_Q30 + (t_c <<< 1);
        b_c    = ONE_Q30 - (t_c <<< 1);
        flag_c = a_c[ARG_W-1] || b_c[ARG_W-1];
        if (a_c[ARG_W-1])
        begin
            a_c = '0;
        end
        if (b_c[ARG_W-1])
        begin
            b_c = '0;
        end
    end

    logic [RAD_W-1:0] rad_a_reg, rad_b_reg;

    // Square root chain: stage k of each lane feeds cell k. Roll and yaw operands and the
    // clamp flag ride alongside.
    logic [RAD_W-1:0]        rad_a [0:ROOT_W];
    logic [RAD_W-1:0]        rad_b [0:ROOT_W];
    logic [REM_W-1:0]        rem_a [0:ROOT_W];
    logic [REM_W-1:0]        rem_b [0:ROOT_W];
    logic [ROOT_W-1:0]       root_a [0:ROOT_W];
    logic [ROOT_W-1:0]       root_b [0:ROOT_W];
    logic signed [ARG_W-1:0] psr_reg [0:ROOT_W];
    logic signed [ARG_W-1:0] pcr_reg [0:ROOT_W];
    logic signed [ARG_W-1:0] psy_reg [0:ROOT_W];
    logic signed [ARG_W-1:0] pcy_reg [0:ROOT_W];
    logic                    pflag_reg [0:ROOT_W];
    logic                    vsq_reg [0:ROOT_W];

    assign rad_a[0]  = rad_a_reg;
    assign rad_b[0]  = rad_b_reg;
    assign rem_a[0]  = '0;
    assign rem_b[0]  = '0;
    assign root_a[0] = '0;
    assign root_b[0] = '0;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_a_reg    <= {a_c[RAD_W-21:0], 20'b0};
            rad_b_reg    <= {b_c[RAD_W-21:0], 20'b0};
            psr_reg[0]   <= sr_c;
            pcr_reg[0]   <= cr_c;
            psy_reg[0]   <= sy_c;
            pcy_reg[0]   <= cy_c;
            pflag_reg[0] <= flag_c;
            for (int k = 1; k <= ROOT_W; k++)
            begin
                psr_reg[k]   <= psr_reg[k-1];
                pcr_reg[k]   <= pcr_reg[k-1];
                psy_reg[k]   <= psy_reg[k-1];
                pcy_reg[k]   <= pcy_reg[k-1];
                pflag_reg[k] <= pflag_reg[k-1];
            end
        end
    end

    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_sqrt
        qte_sqrt_cell u_sqrt_a (
            .clk      (clk),
            .en       (en),
            .rad_in   (rad_a[k]),
            .rem_in   (rem_a[k]),
            .root_in  (root_a[k]),
            .rad_out  (rad_a[k+1]),
            .rem_out  (rem_a[k+1]),
            .root_out (root_a[k+1])
        );
        qte_sqrt_cell u_sqrt_b (
            .clk      (clk),
            .en       (en),
            .rad_in   (rad_b[k]),
            .rem_in   (rem_b[k]),
            .root_in  (root_b[k]),
            .rad_out  (rad_b[k+1]),
            .rem_out  (rem_b[k+1]),
            .root_out (root_b[k+1])
        );
    end

    // Pre-rotation stage: a vector in the left half-plane is turned by a quarter turn.
    // A zero vector is marked so that its angle comes out as zero.
    logic signed [X_W-1:0] op_y [LANES];
    logic signed [X_W-1:0] op_x [LANES];
    logic signed [X_W-1:0] pre_x [LANES];
    logic signed [X_W-1:0] pre_y [LANES];
    logic signed [Z_W-1:0] pre_z [LANES];
    logic                  pre_zero [LANES];

    always_comb
    begin
        op_y[0] = X_W'(psr_reg[ROOT_W]);
        op_x[0] = X_W'(pcr_reg[ROOT_W]);
        op_y[1] = X_W'(root_a[ROOT_W]);
        op_x[1] = X_W'(root_b[ROOT_W]);
        op_y[2] = X_W'(psy_reg[ROOT_W]);
        op_x[2] = X_W'(pcy_reg[ROOT_W]);
        for (int j = 0; j < LANES; j++)
        begin
            pre_zero[j] = (op_x[j] == '0) && (op_y[j] == '0);
            pre_x[j]    = op_x[j];
            pre_y[j]    = op_y[j];
            pre_z[j]    = '0;
            if (op_x[j][X_W-1])
            begin
                if (!op_y[j][X_W-1])
                begin
                    pre_x[j] = op_y[j];
                    pre_y[j] = -op_x[j];
                    pre_z[j] = HALF_PI_Q30;
                end
                else
                begin
                    pre_x[j] = -op_y[j];
                    pre_y[j] = op_x[j];
                    pre_z[j] = -HALF_PI_Q30;
                end
            end
        end
    end

    logic signed [X_W-1:0] px_reg [LANES];
    logic signed [X_W-1:0] py_reg [LANES];
    logic signed [Z_W-1:0] pz_reg [LANES];

    logic signed [X_W-1:0] cx [LANES][0:CORDIC_STAGES];
    logic signed [X_W-1:0] cy [LANES][0:CORDIC_STAGES];
    logic signed [Z_W-1:0] cz [LANES][0:CORDIC_STAGES];
    logic                  czero_reg [LANES][0:CORDIC_STAGES];
    logic                  cflag_reg [0:CORDIC_STAGES];
    logic                  vcd_reg [0:CORDIC_STAGES];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < LANES; j++)
            begin
                px_reg[j]       <= pre_x[j];
                py_reg[j]       <= pre_y[j];
                pz_reg[j]       <= pre_z[j];
                czero_reg[j][0] <= pre_zero[j];
                for (int i = 1; i <= CORDIC_STAGES; i++)
                begin
                    czero_reg[j][i] <= czero_reg[j][i-1];
                end
            end
            cflag_reg[0] <= pflag_reg[ROOT_W];
            for (int i = 1; i <= CORDIC_STAGES; i++)
            begin
                cflag_reg[i] <= cflag_reg[i-1];
            end
        end
    end

    for (genvar j = 0; j < LANES; j++)
    begin : g_lane
        assign cx[j][0] = px_reg[j];
        assign cy[j][0] = py_reg[j];
        assign cz[j][0] = pz_reg[j];
        for (genvar i = 0; i < CORDIC_STAGES; i++)
        begin : g_stage
            qte_cordic_cell #(
                .SHIFT (i)
            ) u_cordic (
                .clk   (clk),
                .en    (en),
                .x_in  (cx[j][i]),
                .y_in  (cy[j][i]),
                .z_in  (cz[j][i]),
                .x_out (cx[j][i+1]),
                .y_out (cy[j][i+1]),
                .z_out (cz[j][i+1])
            );
        end
    end

    // Output stage: pitch is doubled and offset, then every angle is rounded from Q30 to
    // Q13 and saturated.
    function automatic logic [ANGLE_W-1:0] to_q13(input logic signed [Z_W+1:0] v);
        logic signed [Z_W+1:0] r;
        logic [ANGLE_W-1:0]    q;
        r = (v + (Z_W+2)'(65536)) >>> 17;
        if (r > (Z_W+2)'(ANGLE_MAX))
        begin
            q = ANGLE_MAX;
        end
        else if (r < -(Z_W+2)'(ANGLE_MAX))
        begin
            q = -ANGLE_MAX;
        end
        else
        begin
            q = r[ANGLE_W-1:0];
        end
        return q;
    endfunction

    logic signed [Z_W+1:0] ang [LANES];
    logic signed [Z_W+1:0] pitch_v;

    always_comb
    begin
        for (int j = 0; j < LANES; j++)
        begin
            ang[j] = czero_reg[j][CORDIC_STAGES] ? '0 : (Z_W+2)'(cz[j][CORDIC_STAGES]);
        end
        pitch_v = (ang[1] <<< 1) - (Z_W+2)'(FILE_HALF_PI_Q30);
    end

    logic [47:0] out_data_reg;
    logic        out_flag_reg;
    logic        out_valid_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= {to_q13(ang[2]), to_q13(pitch_v), to_q13(ang[0])};
            out_flag_reg <= cflag_reg[CORDIC_STAGES];
        end
    end

    // Valid bits of every stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k <= ROOT_W; k++)
            begin
                vsq_reg[k] <= 1'b0;
            end
            for (int i = 0; i <= CORDIC_STAGES; i++)
            begin
                vcd_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            v0_reg     <= s_tvalid;
            vsq_reg[0] <= v0_reg;
            for (int k = 1; k <= ROOT_W; k++)
            begin
                vsq_reg[k] <= vsq_reg[k-1];
            end
            vcd_reg[0] <= vsq_reg[ROOT_W];
            for (int i = 1; i <= CORDIC_STAGES; i++)
            begin
                vcd_reg[i] <= vcd_reg[i-1];
            end
            out_valid_reg <= vcd_reg[CORDIC_STAGES];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_flag_reg;

`ifndef ASSERT_OFF
    a_ready_follows_output: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow the output register state");

    a_roll_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata[15:0]) <= ANGLE_MAX &&
                      $signed(m_tdata[15:0]) >= -ANGLE_MAX))
        else $error("roll angle outside the saturation range");

    a_pitch_yaw_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata[31:16]) <= ANGLE_MAX &&
                      $signed(m_tdata[31:16]) >= -ANGLE_MAX &&
                      $signed(m_tdata[47:32]) <= ANGLE_MAX &&
                      $signed(m_tdata[47:32]) >= -ANGLE_MAX))
        else $error("pitch or yaw angle outside the saturation range");

    a_stall_freezes_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vcd_reg[CORDIC_STAGES]) && $stable(vsq_reg[ROOT_W]))
        else $error("pipeline moved while the output was stalled");
`endif

endmodule
